// ===== rtl/scbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbp_pkg
// Pool geometry, class table, status codes and link helpers for the
// size class buffer pool.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int COUNT_64    = 8;
  localparam int COUNT_128   = 4;
  localparam int COUNT_256   = 4;
  localparam int COUNT_512   = 4;
  localparam int COUNT_1024  = 1;
  localparam int NUM_CLASSES = 5;
  localparam int MAX_CLASSES = 5;

  localparam int CLASS_COUNT [MAX_CLASSES] = '{COUNT_64, COUNT_128, COUNT_256,
                                               COUNT_512, COUNT_1024};
  localparam int CLASS_SIZE  [MAX_CLASSES] = '{64, 128, 256, 512, 1024};

  // payload widths
  localparam int SIZE_W   = 12;
  localparam int HANDLE_W = 5;
  localparam int GRANT_W  = 11;
  localparam int STAT_W   = 2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_IN_USE = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // first buffer number of class c
  function automatic int class_start(input int c);
    int base;
    base = 0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (k < c) base = base + CLASS_COUNT[k];
    end
    return base;
  endfunction

  localparam int TOTAL_BUFS = class_start(NUM_CLASSES);
  localparam int DEPTH      = (TOTAL_BUFS > 0) ? TOTAL_BUFS : 1;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  // highest class whose start is not above idx
  function automatic logic [CLS_W-1:0] class_of(input logic [IDX_W-1:0] idx);
    logic [CLS_W-1:0] cls;
    cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (int'(idx) >= class_start(c)) cls = CLS_W'(c);
    end
    return cls;
  endfunction

  // link value of an entry that was never written
  function automatic link_t link_init(input logic [IDX_W-1:0] idx);
    link_t lk;
    lk.vld = 1'b0;
    lk.idx = '0;
    if (int'(idx) != class_start(int'(class_of(idx)))) begin
      lk.vld = 1'b1;
      lk.idx = idx - IDX_W'(1);
    end
    return lk;
  endfunction

  function automatic link_t head_init(input int c);
    link_t lk;
    lk.vld = (CLASS_COUNT[c] > 0);
    lk.idx = lk.vld ? IDX_W'(class_start(c) + CLASS_COUNT[c] - 1) : '0;
    return lk;
  endfunction

endpackage

// ===== rtl/size_class_buffer_pool_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_buffer_pool_unit
// Segregated free list allocator: five LIFO lists of 64 to 1024 byte buffers.
// ----------------------------------------------------------------------------
// A request is taken in the idle state while the link_mem memory is read
// into rdata_r; the list update and the result register load happen in the
// execute state, from that registered read data. Allocate pops the head of
// the first non-empty class big enough for req_size; free pushes the buffer
// back on the head of its own class. in_stall is high while a request is in
// flight, and the execute state waits as long as an earlier result is still
// held by out_stall. No clearing pass is needed after reset.
module size_class_buffer_pool_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [scbp_pkg::SIZE_W-1:0]    in_req_size,
  input  logic [scbp_pkg::HANDLE_W-1:0]  in_buf_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [scbp_pkg::STAT_W-1:0]    out_status,
  output logic [scbp_pkg::HANDLE_W-1:0]  out_handle,
  output logic [scbp_pkg::GRANT_W-1:0]   out_granted_size
);
  import scbp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;

  // list state
  link_t      head_r    [NUM_CLASSES];
  logic       in_use_r  [DEPTH];
  logic       written_r [DEPTH];
  link_t      link_mem  [DEPTH];
  link_t      rdata_r;

  // request held for the execute state
  logic             mode_r;
  logic             found_r;
  logic             range_ok_r;
  logic [CLS_W-1:0] cls_r;
  logic [IDX_W-1:0] bidx_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [GRANT_W-1:0]  grant_r;

  logic             accept;
  logic             exec_fire;
  logic             found;
  logic [CLS_W-1:0] sel_cls;
  logic             range_ok;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] raddr;
  link_t            head_nxt;
  logic             alloc_ok;
  logic             free_ok;
  logic             mem_we;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // first fitting class with a free buffer
  always_comb begin
    found   = 1'b0;
    sel_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!found && (in_req_size != '0) && (int'(in_req_size) <= CLASS_SIZE[c]) &&
          head_r[c].vld) begin
        found   = 1'b1;
        sel_cls = CLS_W'(c);
      end
    end
  end

  assign range_ok = (int'(in_buf_handle) < TOTAL_BUFS);
  assign free_idx = IDX_W'(in_buf_handle);
  assign raddr    = (in_mode == MODE_FREE) ? free_idx : head_r[sel_cls].idx;

  // popped buffer's successor, reset order if never linked
  assign head_nxt = written_r[bidx_r] ? rdata_r : link_init(bidx_r);
  assign alloc_ok = (mode_r == MODE_ALLOC) && found_r;
  assign free_ok  = (mode_r == MODE_FREE) && range_ok_r && in_use_r[bidx_r];
  assign mem_we   = exec_fire && free_ok;

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[bidx_r] <= head_r[cls_r];
    if (accept) rdata_r <= link_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      found_r    <= found;
      range_ok_r <= range_ok;
      cls_r      <= (in_mode == MODE_FREE) ? class_of(free_idx) : sel_cls;
      bidx_r     <= raddr;
    end
    if (exec_fire) begin
      status_r <= ST_OK;
      handle_r <= '0;
      grant_r  <= '0;
      if (mode_r == MODE_ALLOC) begin
        if (found_r) begin
          handle_r <= HANDLE_W'(bidx_r);
          grant_r  <= GRANT_W'(CLASS_SIZE[cls_r]);
        end else begin
          status_r <= ST_NO_FIT;
        end
      end else if (!range_ok_r) begin
        status_r <= ST_BAD_INDEX;
      end else if (!in_use_r[bidx_r]) begin
        status_r <= ST_NOT_IN_USE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) head_r[c] <= head_init(c);
      for (int i = 0; i < DEPTH; i++) begin
        in_use_r[i]  <= 1'b0;
        written_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept) state_r <= S_EXEC;
      if (exec_fire) begin
        state_r     <= S_IDLE;
        out_valid_r <= 1'b1;
        if (alloc_ok) begin
          head_r[cls_r]    <= head_nxt;
          in_use_r[bidx_r] <= 1'b1;
        end
        if (free_ok) begin
          head_r[cls_r].vld <= 1'b1;
          head_r[cls_r].idx <= bidx_r;
          in_use_r[bidx_r]  <= 1'b0;
          written_r[bidx_r] <= 1'b1;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_handle       = handle_r;
  assign out_granted_size = grant_r;

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("request not taken into execute");

  a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_valid_r && out_stall |=> (state_r == S_EXEC))
    else $error("held result overwritten");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && alloc_ok |=> in_use_r[bidx_r])
    else $error("allocated buffer not marked in use");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> (handle_r == '0) && (grant_r == '0))
    else $error("failed request carries a buffer");
`endif

endmodule
